[rtl/hxp_pkg.sv]
// Shared types and constants for the hex text to 128-bit integer parser.
// Used by every module of the block; depends on nothing else.
package hxp_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    // Register indexes of the configuration channel.
    localparam logic [1:0] REG_DIGIT_LIMIT = 2'd0;
    localparam logic [1:0] REG_STRICT_FORM = 2'd1;

    // Width of the value accumulator and of the result value.
    localparam int ACC_W = 128;

    // Count of entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // One classified character as it travels from front to back.
    typedef struct packed {
        logic       last;
        logic       none;
        logic       is_space;
        logic       is_zero;
        logic       is_hex;
        logic [3:0] digit;
    } char_entry_t;

endpackage

[rtl/hxp_front.sv]
// Front end: classifies each incoming text byte into a queue entry.
// Depends on hxp_pkg for the entry type.
module hxp_front
(
    input  logic [7:0]          text_byte,
    input  logic                end_of_string,
    input  logic                no_byte,
    output hxp_pkg::char_entry_t entry
);

    logic       dec_digit;
    logic       upper_hex;
    logic       lower_hex;
    logic [7:0] digit_wide;

    // Character classes of the raw byte.
    always_comb
    begin
        dec_digit  = (text_byte >= 8'h30) && (text_byte <= 8'h39);
        upper_hex  = (text_byte >= 8'h41) && (text_byte <= 8'h46);
        lower_hex  = (text_byte >= 8'h61) && (text_byte <= 8'h66);
        priority if (dec_digit)
        begin
            digit_wide = text_byte - 8'h30;
        end
        else if (upper_hex)
        begin
            digit_wide = text_byte - 8'h37;
        end
        else if (lower_hex)
        begin
            digit_wide = text_byte - 8'h57;
        end
        else
        begin
            digit_wide = 8'd0;
        end
    end

    // Pack the classification for the back end.
    always_comb
    begin
        entry.last     = end_of_string;
        entry.none     = no_byte;
        entry.is_space = (text_byte == 8'd32) ||
                         ((text_byte >= 8'd9) && (text_byte <= 8'd13));
        entry.is_zero  = (text_byte == 8'h30);
        entry.is_hex   = dec_digit || upper_hex || lower_hex;
        entry.digit    = digit_wide[3:0];
    end

endmodule

[rtl/hxp_queue.sv]
// Short queue that decouples the classifying front from the parsing back.
// Depends on hxp_pkg for the entry type and the depth.
module hxp_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hxp_pkg::char_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output hxp_pkg::char_entry_t head_entry
);

    localparam int PTR_W = (hxp_pkg::QUEUE_DEPTH > 1) ? $clog2(hxp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(hxp_pkg::QUEUE_DEPTH + 1);

    hxp_pkg::char_entry_t slot_reg [hxp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    // Pointer and fill count updates, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(hxp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(hxp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign full       = (count_reg == CNT_W'(hxp_pkg::QUEUE_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

endmodule

[rtl/hxp_back.sv]
// Back end: string state, hex accumulation, verdict and the result register.
// Depends on hxp_pkg for status codes, entry type and accumulator width.
module hxp_back
#(
    parameter int MAX_DIGITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [5:0]                 digit_limit,
    input  logic                       strict_form,
    input  logic                       entry_valid,
    input  hxp_pkg::char_entry_t       entry,
    output logic                       entry_pop,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [1:0]                 status,
    output logic [hxp_pkg::ACC_W-1:0]  value
);

    typedef enum logic [1:0]
    {
        PH_LEAD,
        PH_ZERO,
        PH_BODY
    } phase_t;

    phase_t                    phase_reg;
    phase_t                    phase_next;
    logic                      zeros_reg;
    logic                      zeros_next;
    logic [5:0]                pend_reg;
    logic [5:0]                pend_next;
    logic [5:0]                count_reg;
    logic [5:0]                count_next;
    logic                      bad_reg;
    logic                      bad_next;
    logic [hxp_pkg::ACC_W-1:0] acc_reg;
    logic [hxp_pkg::ACC_W-1:0] acc_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;
    logic [hxp_pkg::ACC_W-1:0] value_reg;

    logic [5:0]                lim;
    logic [5:0]                lim_plus;
    logic [6:0]                pend_sum;
    logic                      take_pend;
    logic                      take_char;
    logic [5:0]                count_base;

    // Effective digit limit, clamped into one to MAX_DIGITS.
    always_comb
    begin
        priority if (digit_limit == 6'd0)
        begin
            lim = 6'd1;
        end
        else if (digit_limit > 6'(MAX_DIGITS))
        begin
            lim = 6'(MAX_DIGITS);
        end
        else
        begin
            lim = digit_limit;
        end
        lim_plus = lim + 6'd1;
    end

    // The back end moves on unless a result would overwrite a waiting one.
    assign entry_pop = entry_valid && (!entry.last || !out_valid_reg || result_ready);

    // Per-character update of the string state.
    always_comb
    begin
        phase_next = phase_reg;
        zeros_next = zeros_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        acc_next   = acc_reg;
        take_pend  = 1'b0;
        take_char  = 1'b0;
        pend_sum   = 7'(count_reg) + 7'(pend_reg);

        if (!entry.none)
        begin
            priority if (strict_form)
            begin
                take_char = 1'b1;
            end
            else if (entry.is_space)
            begin
                if (phase_reg != PH_LEAD && pend_reg != 6'd63)
                begin
                    pend_next = pend_reg + 6'd1;
                end
            end
            else if (entry.is_zero && phase_reg != PH_BODY && pend_reg == 6'd0)
            begin
                phase_next = PH_ZERO;
                zeros_next = 1'b1;
            end
            else
            begin
                take_pend = 1'b1;
                take_char = 1'b1;
            end
        end

        // Trailing spaces followed by more text become bad characters.
        count_base = count_reg;
        if (take_pend)
        begin
            count_base = (pend_sum > 7'(lim_plus)) ? lim_plus : pend_sum[5:0];
            if (pend_reg != 6'd0)
            begin
                bad_next = 1'b1;
            end
            pend_next = 6'd0;
        end

        // A significant character is counted and shifted in.
        if (take_char)
        begin
            phase_next = PH_BODY;
            count_next = (count_base <= lim) ? count_base + 6'd1 : count_base;
            if (!entry.is_hex)
            begin
                bad_next = 1'b1;
            end
            acc_next = {acc_reg[hxp_pkg::ACC_W-5:0],
                        (entry.is_hex ? entry.digit : 4'd0)};
        end
    end

    // Verdict from the updated state.
    always_comb
    begin
        if (strict_form)
        begin
            status_next = (count_next != lim || bad_next) ?
                          hxp_pkg::ST_INVALID : hxp_pkg::ST_OK;
        end
        else if (count_next > lim)
        begin
            status_next = hxp_pkg::ST_TOO_LARGE;
        end
        else if (count_next == 6'd0)
        begin
            status_next = zeros_next ? hxp_pkg::ST_OK : hxp_pkg::ST_INVALID;
        end
        else
        begin
            status_next = bad_next ? hxp_pkg::ST_INVALID : hxp_pkg::ST_OK;
        end
    end

    // Result register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (entry_pop && entry.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // String state; it returns to the reset values after every end item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            zeros_reg     <= 1'b0;
            pend_reg      <= 6'd0;
            count_reg     <= 6'd0;
            bad_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (entry_pop)
            begin
                if (entry.last)
                begin
                    phase_reg <= PH_LEAD;
                    zeros_reg <= 1'b0;
                    pend_reg  <= 6'd0;
                    count_reg <= 6'd0;
                    bad_reg   <= 1'b0;
                    acc_reg   <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    zeros_reg <= zeros_next;
                    pend_reg  <= pend_next;
                    count_reg <= count_next;
                    bad_reg   <= bad_next;
                    acc_reg   <= acc_next;
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (entry_pop && entry.last)
        begin
            status_reg <= status_next;
            value_reg  <= (status_next == hxp_pkg::ST_OK) ? acc_next : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign value        = value_reg;

endmodule

[rtl/hex_text_to_uint128_parser.sv]
// Hex text to 128-bit unsigned integer parser, top level.
// Throughput: one text byte per cycle while the queue is not full; the string state updates once per popped entry.
// An end item passes through the queue and then into the result register, which drives m_tvalid,
// when no earlier result waits; a waiting result holds end items in the queue.
// The two-entry queue and the result register let input and output stall on their own.
// Reset: rst_n clears all string state, the queue and the result valid at once;
// digit_limit resets to 16 and strict_form to 0.
module hex_text_to_uint128_parser
#(
    parameter int MAX_DIGITS = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    // Input stream.
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] text_byte
    input  logic           s_tlast,   // end_of_string
    input  logic           s_tuser,   // [0] no_byte
    // Result stream.
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [127:0]   m_tdata,   // [63:0] value_low, [127:64] value_high
    output logic [1:0]     m_tuser,   // [1:0] status
    // Configuration write channel.
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [5:0]     cfg_data
);

    logic [5:0]           limit_reg;
    logic                 strict_reg;
    hxp_pkg::char_entry_t front_entry;
    hxp_pkg::char_entry_t head_entry;
    logic                 queue_full;
    logic                 queue_valid;
    logic                 queue_pop;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= 6'd16;
            strict_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hxp_pkg::REG_DIGIT_LIMIT: limit_reg  <= cfg_data;
                hxp_pkg::REG_STRICT_FORM: strict_reg <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    hxp_front u_front
    (
        .text_byte     (s_tdata),
        .end_of_string (s_tlast),
        .no_byte       (s_tuser),
        .entry         (front_entry)
    );

    assign s_tready = !queue_full;

    hxp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid && s_tready),
        .push_entry (front_entry),
        .full       (queue_full),
        .pop        (queue_pop),
        .not_empty  (queue_valid),
        .head_entry (head_entry)
    );

    hxp_back
    #(
        .MAX_DIGITS (MAX_DIGITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .digit_limit  (limit_reg),
        .strict_form  (strict_reg),
        .entry_valid  (queue_valid),
        .entry        (head_entry),
        .entry_pop    (queue_pop),
        .result_valid (m_tvalid),
        .result_ready (m_tready),
        .status       (m_tuser),
        .value        (m_tdata)
    );

    // A result that is not ok carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != hxp_pkg::ST_OK) |-> (m_tdata == '0))
        else $error("non-ok result carries a nonzero value");

    // The status code is always one of the three defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= hxp_pkg::ST_TOO_LARGE))
        else $error("undefined status code");

    // The back end never takes an entry from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_pop |-> queue_valid)
        else $error("pop from empty queue");

    // A full queue holds off the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !s_tready)
        else $error("input accepted while queue full");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the hex text to 128-bit integer parser.
// Depends on hxp_pkg and hex_text_to_uint128_parser, which needs hxp_front, hxp_queue and hxp_back.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_DIGITS    = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTING_ITEMS = 60;

    // Register index that no register answers to.
    localparam logic [1:0] REG_SPARE = 2'd2;

    typedef enum logic [1:0] {SCAN_LEADING, SCAN_ZEROS, SCAN_BODY} scan_phase_t;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] value_high;
        logic [63:0] value_low;
    } parse_result_t;

    logic         clk;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'h00;
    logic         s_tlast   = 1'b0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = 2'd0;
    logic [5:0]   cfg_data  = 6'd0;

    // Configuration as the parser should see it.
    logic [5:0]   cfg_limit  = 6'd16;
    logic         cfg_strict = 1'b0;

    // String state of the parser as predicted here.
    scan_phase_t               scan_phase     = SCAN_LEADING;
    logic                      zeros_dropped  = 1'b0;
    int                        pending_blanks = 0;
    int                        sig_count      = 0;
    logic                      bad_char       = 1'b0;
    logic [hxp_pkg::ACC_W-1:0] accum          = '0;

    parse_result_t parsed_values_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    hex_text_to_uint128_parser #(.MAX_DIGITS(MAX_DIGITS)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The result side stalls at random.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic note_failure(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        if (error_count < 10)
            $display("Mismatch in %s at cycle %0d: expected %h, got %h",
                     what, cycle_count, want, got);
        error_count++;
    endtask

    // Every accepted result is checked against the oldest predicted one.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (parsed_values_due.size() == 0)
            begin
                note_failure("status of a result nobody asked for", 64'd0, 64'(m_tuser));
            end
            else
            begin
                if (m_tuser !== parsed_values_due[0].status)
                    note_failure("status", 64'(parsed_values_due[0].status), 64'(m_tuser));
                if (m_tdata[127:64] !== parsed_values_due[0].value_high)
                    note_failure("value_high", parsed_values_due[0].value_high,
                                 m_tdata[127:64]);
                if (m_tdata[63:0] !== parsed_values_due[0].value_low)
                    note_failure("value_low", parsed_values_due[0].value_low, m_tdata[63:0]);
                void'(parsed_values_due.pop_front());
            end
        end
    end

    function automatic int active_limit();
        if (cfg_limit < 1)
            return 1;
        if (cfg_limit > MAX_DIGITS)
            return MAX_DIGITS;
        return cfg_limit;
    endfunction

    function automatic logic is_blank_byte(input logic [7:0] ch);
        return (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
    endfunction

    // Digit value of a character, or 16 for anything that is not hex.
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
            return 5'(ch - "0");
        if (ch >= "A" && ch <= "F")
            return 5'(ch - "A" + 8'd10);
        if (ch >= "a" && ch <= "f")
            return 5'(ch - "a" + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return 8'("0" + v);
        if ($urandom_range(1))
            return 8'("a" + v - 10);
        return 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] random_blank();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? 8'h20 : 8'(9 + r);
    endfunction

    // A significant character is counted and shifted into the value.
    task automatic shift_in_char(input logic [7:0] ch, input int lim);
        logic [4:0] nib;
        nib = hex_nibble(ch);
        if (sig_count <= lim)
            sig_count++;
        if (nib > 5'd15)
        begin
            bad_char = 1'b1;
            nib = 5'd0;
        end
        accum = {accum[hxp_pkg::ACC_W-5:0], nib[3:0]};
    endtask

    // Predicts the effect of one accepted request on the string state.
    task automatic track_hex_char(input logic [7:0] ch, input logic eos, input logic none);
        int            lim;
        int            sum;
        parse_result_t res;
        lim = active_limit();
        if (!none)
        begin
            if (cfg_strict)
            begin
                scan_phase = SCAN_BODY;
                shift_in_char(ch, lim);
            end
            else if (is_blank_byte(ch))
            begin
                if (scan_phase != SCAN_LEADING && pending_blanks < 63)
                    pending_blanks++;
            end
            else if (ch == "0" && scan_phase != SCAN_BODY && pending_blanks == 0)
            begin
                scan_phase = SCAN_ZEROS;
                zeros_dropped = 1'b1;
            end
            else
            begin
                // Whitespace held back so far turns out to be inside the string.
                if (pending_blanks > 0)
                    bad_char = 1'b1;
                sum = sig_count + pending_blanks;
                sig_count = (sum > lim + 1) ? lim + 1 : sum;
                pending_blanks = 0;
                scan_phase = SCAN_BODY;
                shift_in_char(ch, lim);
            end
        end

        if (eos)
        begin
            if (cfg_strict)
                res.status = (sig_count != lim || bad_char) ?
                             hxp_pkg::ST_INVALID : hxp_pkg::ST_OK;
            else if (sig_count > lim)
                res.status = hxp_pkg::ST_TOO_LARGE;
            else if (sig_count == 0)
                res.status = zeros_dropped ? hxp_pkg::ST_OK : hxp_pkg::ST_INVALID;
            else
                res.status = bad_char ? hxp_pkg::ST_INVALID : hxp_pkg::ST_OK;
            res.value_high = (res.status == hxp_pkg::ST_OK) ? accum[127:64] : 64'd0;
            res.value_low  = (res.status == hxp_pkg::ST_OK) ? accum[63:0] : 64'd0;
            parsed_values_due.push_back(res);

            scan_phase     = SCAN_LEADING;
            zeros_dropped  = 1'b0;
            pending_blanks = 0;
            sig_count      = 0;
            bad_char       = 1'b0;
            accum          = '0;
        end
    endtask

    // Sends one request on the text stream, idling first at random.
    task automatic push_text_byte(input logic [7:0] ch, input logic eos, input logic none);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eos;
        s_tuser  <= none;
        do
            @(posedge clk);
        while (!s_tready);
        track_hex_char(ch, eos, none);
        if (!none || eos)
            items_sent++;
    endtask

    task automatic push_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            push_text_byte(text[i], i == text.len() - 1, 1'b0);
    endtask

    // Holds the text stream until every predicted result has come out.
    task automatic wait_parser_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (parsed_values_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == hxp_pkg::REG_DIGIT_LIMIT)
            cfg_limit = val;
        else if (idx == hxp_pkg::REG_STRICT_FORM)
            cfg_strict = val[0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Empty input, an all-blank string and a string of zeros only.
    task automatic test_empty_and_zeros();
        push_text_byte(8'h00, 1'b1, 1'b1);
        push_text("\t00\015");
        push_text("  ");
    endtask

    // Inner whitespace, a high byte and a NUL byte all make the string invalid.
    task automatic test_bad_characters();
        push_text("f F");
        push_text_byte("A", 1'b0, 1'b0);
        push_text_byte(8'hFF, 1'b1, 1'b0);
        push_text_byte(8'h00, 1'b1, 1'b0);
    endtask

    // An item with no character and no end mark changes nothing.
    task automatic test_blank_item();
        push_text_byte("9", 1'b0, 1'b0);
        push_text_byte(8'hA5, 1'b0, 1'b1);
        push_text_byte("1", 1'b1, 1'b0);
    endtask

    // A limit of zero acts as one, a limit above the maximum as the maximum.
    task automatic test_limit_range();
        wait_parser_idle();
        write_reg(hxp_pkg::REG_DIGIT_LIMIT, 6'd0);
        push_text("7");
        push_text("77");
        wait_parser_idle();
        write_reg(hxp_pkg::REG_DIGIT_LIMIT, 6'd63);
        write_reg(REG_SPARE, 6'h3F);
        push_text("1");
    endtask

    // Switching to strict form in the middle of a string.
    task automatic test_mode_switch();
        wait_parser_idle();
        write_reg(hxp_pkg::REG_DIGIT_LIMIT, 6'd3);
        write_reg(hxp_pkg::REG_STRICT_FORM, 6'd0);
        push_text_byte("1", 1'b0, 1'b0);
        push_text_byte("2", 1'b0, 1'b0);
        wait_parser_idle();
        write_reg(hxp_pkg::REG_STRICT_FORM, 6'd1);
        push_text_byte("3", 1'b1, 1'b0);
        push_text("1");
    endtask

    // Builds one string shaped for the current mode and limit, then sends it.
    task automatic send_random_string();
        logic [7:0] text[$];
        int         lim;
        int         roll;
        int         pick;
        int         ndig;
        int         i;
        logic       all_ones;
        logic       end_apart;
        lim  = active_limit();
        roll = $urandom_range(99);
        if (roll < 4)
        begin
            // Nothing at all.
        end
        else if (roll < 8)
        begin
            repeat ($urandom_range(1, 3)) text.push_back(random_blank());
        end
        else
        begin
            if (!cfg_strict)
            begin
                if ($urandom_range(1))
                    repeat ($urandom_range(1, 3)) text.push_back(random_blank());
                if ($urandom_range(1))
                    repeat ($urandom_range(1, 3)) text.push_back("0");
            end
            pick = $urandom_range(99);
            if (cfg_strict)
                ndig = (pick < 70) ? lim : (pick < 85) ? lim - 1 : lim + 1;
            else if (pick < 5)
                ndig = 0;
            else if (pick < 55)
                ndig = $urandom_range(1, (lim < 6) ? lim : 6);
            else if (pick < 80)
                ndig = lim;
            else
                ndig = lim + $urandom_range(1, 2);
            all_ones = (ndig == lim) && ($urandom_range(9) == 0);
            for (i = 0; i < ndig; i++)
            begin
                if (all_ones)
                    text.push_back($urandom_range(1) ? "f" : "F");
                else
                    text.push_back(random_hex_char());
            end
            if (!cfg_strict && $urandom_range(1))
                repeat ($urandom_range(1, 3)) text.push_back(random_blank());

            // Some strings get a stray byte or an inner blank.
            pick = $urandom_range(99);
            if (text.size() > 0 && pick < 12)
                text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
            else if (text.size() >= 2 && pick < 18)
                text.insert($urandom_range(1, text.size() - 1), random_blank());
        end

        end_apart = (text.size() == 0) || ($urandom_range(9) == 0);
        for (i = 0; i < text.size(); i++)
        begin
            if ($urandom_range(19) == 0)
                push_text_byte(8'($urandom_range(255)), 1'b0, 1'b1);
            push_text_byte(text[i], !end_apart && (i == text.size() - 1), 1'b0);
        end
        if (end_apart)
            push_text_byte(8'($urandom_range(255)), 1'b1, 1'b1);
    endtask

    // Random strings over a range of limits and both forms.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int         k;
        int         target;
        logic [5:0] lim;
        logic       strict;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (k = 0; k < 8; k++)
        begin
            case (k)
                0: begin lim = 6'd16; strict = 1'b0; end
                1: begin lim = 6'd32; strict = 1'b0; end
                2: begin lim = 6'd1;  strict = 1'b0; end
                3: begin lim = 6'd0;  strict = 1'b0; end
                4: begin lim = 6'd63; strict = 1'b0; end
                5: begin lim = 6'($urandom_range(2, 31)); strict = 1'b1; end
                6: begin lim = 6'd32; strict = 1'b1; end
                default: begin lim = 6'($urandom_range(63)); strict = 1'($urandom); end
            endcase
            wait_parser_idle();
            write_reg(hxp_pkg::REG_DIGIT_LIMIT, lim);
            write_reg(hxp_pkg::REG_STRICT_FORM, {5'($urandom_range(31)), strict});
            target = items_sent + SETTING_ITEMS;
            while (items_sent < target)
                send_random_string();
        end
    endtask

    initial
    begin
        send_idle_pct = 17;
        recv_idle_pct = 76;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_zeros();
        test_bad_characters();
        test_blank_item();
        test_limit_range();
        test_mode_switch();
        test_random_traffic(17, 76);
        test_random_traffic(76, 17);
        test_random_traffic(0, 0);

        wait_parser_idle();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
